FILE: src/dsfe_pkg.sv
package dsfe_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int NUM_BOARDS = 8;

    // CRC-16/ARC, kept unreflected; the polynomial is applied MSB first
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BOARD_NUM = 2'd0,
        CFG_DLE_CODE  = 2'd1,
        CFG_STX_CODE  = 2'd2,
        CFG_ETX_CODE  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [3:0] board_num;
        logic [7:0] dle_code;
        logic [7:0] stx_code;
        logic [7:0] etx_code;
    } t_cfg;

    // one classified message byte, front to back
    typedef struct packed {
        logic [7:0]  msg_byte;
        logic        end_of_message;
        logic        open_frame;
        logic [7:0]  mask;
        logic [15:0] crc;        // already reflected, valid with end_of_message
    } t_entry;

    function automatic logic [7:0] bit_rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    function automatic logic [15:0] bit_rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[i] = v[15 - i];
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {bit_rev8(b), 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // one-hot destination mask; zero for board numbers out of range
    function automatic logic [7:0] board_mask(input logic [3:0] board_num);
        logic [7:0] m;
        m = 8'h00;
        if (board_num >= 4'd1 && board_num <= 4'(NUM_BOARDS)) begin
            m = 8'h01 << (board_num - 4'd1);
        end
        return m;
    endfunction

endpackage

FILE: src/dsfe_front.sv
module dsfe_front
    import dsfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_msg_byte,
    input  logic       i_end_of_message,
    input  logic       i_queue_full,
    output logic       o_ready,
    output logic       o_push,
    output t_entry     o_entry
);

    logic        r_in_message;
    logic [15:0] r_crc;
    logic        n_in_message;
    logic [15:0] n_crc;

    logic [7:0]  mask;
    logic [15:0] crc_base;
    logic [15:0] crc_next;

    // mask CRC depends on the board number alone, so it reduces to a small table
    always_comb begin
        mask     = board_mask(i_cfg.board_num);
        crc_base = r_in_message ? r_crc : crc_feed(CRC_INIT, mask);
        crc_next = crc_feed(crc_base, i_msg_byte);
    end

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        o_entry.msg_byte       = i_msg_byte;
        o_entry.end_of_message = i_end_of_message;
        o_entry.open_frame     = !r_in_message;
        o_entry.mask           = mask;
        o_entry.crc            = bit_rev16(crc_next);

        n_in_message = r_in_message;
        n_crc        = r_crc;
        if (o_push) begin
            if (i_end_of_message) begin
                n_in_message = 1'b0;
                n_crc        = CRC_INIT;
            end else begin
                n_in_message = 1'b1;
                n_crc        = crc_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_message <= 1'b0;
            r_crc        <= CRC_INIT;
        end else begin
            r_in_message <= n_in_message;
            r_crc        <= n_crc;
        end
    end

endmodule

FILE: src/dsfe_queue.sv
module dsfe_queue
    import dsfe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // pointers wrap at DEPTH, so any depth works
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/dsfe_back.sv
module dsfe_back
    import dsfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast,
    output logic       o_tuser
);

    typedef enum logic [2:0] {
        PH_OPEN_DLE,
        PH_OPEN_STX,
        PH_MASK,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_CLOSE_DLE,
        PH_CLOSE_ETX
    } t_phase;

    t_phase     r_phase;
    logic       r_started;
    logic       r_dup;
    logic       r_out_valid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic       r_tuser;

    t_phase     phase;
    t_phase     phase_next;
    logic [7:0] cur_byte;
    logic       stuffable;
    logic       need_dup;
    logic       item_done;
    logic       load;

    always_comb begin
        if (r_started) begin
            phase = r_phase;
        end else if (i_entry.open_frame) begin
            phase = PH_OPEN_DLE;
        end else begin
            phase = PH_DATA;
        end

        cur_byte   = i_cfg.dle_code;
        stuffable  = 1'b0;
        phase_next = PH_DATA;
        case (phase)
            PH_OPEN_DLE: begin
                cur_byte   = i_cfg.dle_code;
                phase_next = PH_OPEN_STX;
            end
            PH_OPEN_STX: begin
                cur_byte   = i_cfg.stx_code;
                phase_next = PH_MASK;
            end
            PH_MASK: begin
                cur_byte   = i_entry.mask;
                stuffable  = 1'b1;
                phase_next = PH_DATA;
            end
            PH_DATA: begin
                cur_byte   = i_entry.msg_byte;
                stuffable  = 1'b1;
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                cur_byte   = i_entry.crc[15:8];
                stuffable  = 1'b1;
                phase_next = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                cur_byte   = i_entry.crc[7:0];
                stuffable  = 1'b1;
                phase_next = PH_CLOSE_DLE;
            end
            PH_CLOSE_DLE: begin
                cur_byte   = i_cfg.dle_code;
                phase_next = PH_CLOSE_ETX;
            end
            PH_CLOSE_ETX: begin
                cur_byte   = i_cfg.etx_code;
                phase_next = PH_DATA;
            end
            default: begin
                cur_byte   = i_cfg.dle_code;
                phase_next = PH_DATA;
            end
        endcase

        // first copy of an escape-valued mask, payload or CRC byte gets sent again
        need_dup  = stuffable && !r_dup && (cur_byte == i_cfg.dle_code);
        item_done = !need_dup
                    && ((phase == PH_DATA && !i_entry.end_of_message)
                        || phase == PH_CLOSE_ETX);
        load      = i_valid && (!r_out_valid || i_tready);
    end

    assign o_pop    = load && item_done;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_dup       <= 1'b0;
            r_phase     <= PH_DATA;
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_tdata     <= cur_byte;
            r_tlast     <= item_done;
            r_tuser     <= (phase == PH_CLOSE_ETX);
            if (need_dup) begin
                r_dup     <= 1'b1;
                r_started <= 1'b1;
                r_phase   <= phase;
            end else begin
                r_dup     <= 1'b0;
                r_started <= !item_done;
                r_phase   <= phase_next;
            end
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: src/dle_stx_frame_encoder_crc16_unit.sv
// DLE/STX/ETX frame encoder with CRC-16/ARC.
// Slave stream: one message byte per transfer in s_axis_tdata, s_axis_tlast
//   on the final byte; the first byte after a frame closes opens a new frame.
// Master stream: one framed byte per transfer. m_axis_tlast marks the last
//   byte caused by an input transfer, m_axis_tuser marks the closing ETX.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
//   (0 board number, 1 escape, 2 STX, 3 ETX code); write only when idle.
// Path: an input byte is written into the queue; the back then loads the
//   bytes it causes from the queue head into the output register.
// Throughput: the output register sends one byte per cycle while the
//   receiver is ready; an input transfer causes 1 output byte for a plain
//   data byte, 2 if stuffed, up to 12 for a one-byte message. The front takes a
//   byte per cycle while the queue (QUEUE_DEPTH entries) has room.
// Reset (synchronous, active low) restores the default codes, drops any
//   open frame and CRC, and empties the queue and the output register.
// A stalled receiver holds the output register; the queue then fills and
//   s_axis_tready drops.
module dle_stx_frame_encoder_crc16_unit
    import dsfe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [7:0] msg_byte
    input  logic       s_axis_tlast,     // end_of_message

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [7:0] tx_byte
    output logic       m_axis_tlast,     // run_last
    output logic       m_axis_tuser,     // [0] frame_end

    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_addr,
    input  logic [7:0] i_cfg_wdata
);

    // configuration registers
    t_cfg   r_cfg;

    t_entry front_entry;
    t_entry head_entry;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.board_num <= 4'd1;
            r_cfg.dle_code  <= 8'h10;
            r_cfg.stx_code  <= 8'h02;
            r_cfg.etx_code  <= 8'h03;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_BOARD_NUM: r_cfg.board_num <= i_cfg_wdata[3:0];
                CFG_DLE_CODE:  r_cfg.dle_code  <= i_cfg_wdata;
                CFG_STX_CODE:  r_cfg.stx_code  <= i_cfg_wdata;
                CFG_ETX_CODE:  r_cfg.etx_code  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: frame open tracking, mask and running CRC per byte
    dsfe_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (s_axis_tvalid),
        .i_msg_byte       (s_axis_tdata),
        .i_end_of_message (s_axis_tlast),
        .i_queue_full     (queue_full),
        .o_ready          (s_axis_tready),
        .o_push           (push),
        .o_entry          (front_entry)
    );

    // decouples byte intake from the byte-serial output sequencer
    dsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_entry (head_entry)
    );

    // back: expands each entry into framing, stuffed payload and CRC bytes
    dsfe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (queue_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

`ifndef SYNTHESIS
    // the closing ETX always ends the run of its input transfer
    a_etx_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without run end");

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // nothing is popped from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> queue_valid)
        else $error("queue underflow");

    // the front never pushes into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !queue_full && s_axis_tready)
        else $error("queue overflow");
`endif

endmodule

FILE: bench/dle_stx_frame_encoder_crc16_unit_tb.sv
module dle_stx_frame_encoder_crc16_unit_tb;
    import dsfe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One byte on the framed output stream, as the predictor expects it.
    typedef struct {
        logic [7:0] tx_byte;
        logic       run_last;
        logic       frame_end;
    } t_tx_beat;

    // Idle patterns for the two stream sides.
    typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    // Frame predictor plus the queue of output bytes still owed by the DUT.
    class frame_scoreboard;
        logic [3:0]  board_num;
        logic [7:0]  dle_code;
        logic [7:0]  stx_code;
        logic [7:0]  etx_code;
        bit          frame_open;
        logic [15:0] crc_reg;    // reflected CRC-16/ARC, sent as is
        t_tx_beat    tx_expected[$];
        int          errors;
        int          checked;
        int          frames;

        function new();
            board_num  = 4'd1;
            dle_code   = 8'h10;
            stx_code   = 8'h02;
            etx_code   = 8'h03;
            frame_open = 1'b0;
            crc_reg    = 16'h0000;
        endfunction

        function void set_reg(t_cfg_index idx, logic [7:0] val);
            case (idx)
                CFG_BOARD_NUM: board_num = val[3:0];
                CFG_DLE_CODE:  dle_code  = val;
                CFG_STX_CODE:  stx_code  = val;
                CFG_ETX_CODE:  etx_code  = val;
                default: ;
            endcase
        endfunction

        // LSB-first form of the 0x8005 polynomial
        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++) begin
                r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
            end
            return r;
        endfunction

        function void push_beat(logic [7:0] b, logic fend);
            t_tx_beat beat;
            beat.tx_byte   = b;
            beat.run_last  = 1'b0;
            beat.frame_end = fend;
            tx_expected = {tx_expected, beat};
        endfunction

        // payload bytes that collide with the escape go out twice
        function void push_stuffed(logic [7:0] b);
            push_beat(b, 1'b0);
            if (b == dle_code) begin
                push_beat(b, 1'b0);
            end
        endfunction

        function void note_input(logic [7:0] b, logic eom);
            logic [7:0] mask;
            if (!frame_open) begin
                mask = (board_num >= 4'd1 && board_num <= 4'd8) ?
                       (8'h01 << (board_num - 4'd1)) : 8'h00;
                push_beat(dle_code, 1'b0);
                push_beat(stx_code, 1'b0);
                crc_reg  = crc_step(16'h0000, mask);
                push_stuffed(mask);
                frame_open = 1'b1;
            end
            crc_reg = crc_step(crc_reg, b);
            push_stuffed(b);
            if (eom) begin
                push_stuffed(crc_reg[15:8]);
                push_stuffed(crc_reg[7:0]);
                push_beat(dle_code, 1'b0);
                push_beat(etx_code, 1'b1);
                frame_open = 1'b0;
                crc_reg  = 16'h0000;
            end
            tx_expected[tx_expected.size() - 1].run_last = 1'b1;
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            if (errors <= 30) begin
                $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
            end
        endfunction

        function void check_result(logic [7:0] b, logic rl, logic fe);
            t_tx_beat want;
            if (tx_expected.size() == 0) begin
                errors++;
                if (errors <= 30) begin
                    $display("%0t: unexpected output transfer, expected none, got %02h",
                             $time, b);
                end
                return;
            end
            want = tx_expected.pop_front();
            checked++;
            if (b !== want.tx_byte) flag("tx_byte", want.tx_byte, b);
            if (rl !== want.run_last) flag("run_last", {7'd0, want.run_last}, {7'd0, rl});
            if (fe !== want.frame_end) flag("frame_end", {7'd0, want.frame_end}, {7'd0, fe});
            if (want.frame_end) frames++;
        endfunction
    endclass

    // ---------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ---------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tready = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_addr = 2'd0;
    logic [7:0] cfg_wdata = 8'h00;

    logic       s_axis_tready;
    logic       m_axis_tvalid;
    logic [7:0] m_axis_tdata;     // [7:0] tx_byte
    logic       m_axis_tlast;     // run_last
    logic       m_axis_tuser;     // [0] frame_end

    dle_stx_frame_encoder_crc16_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),       // [7:0] msg_byte
        .s_axis_tlast  (s_tlast),       // end_of_message
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),  // [7:0] tx_byte
        .m_axis_tlast  (m_axis_tlast),  // run_last
        .m_axis_tuser  (m_axis_tuser),  // [0] frame_end
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    frame_scoreboard sb = new();

    int tx_idle_pct  = 0;   // chance per cycle that the sender holds back
    int rx_stall_pct = 0;   // chance per cycle that the receiver stalls
    int rx_hold      = 0;   // pending cycles of forced receiver hold-off
    int msg_left     = 0;   // bytes still to come in the current random message
    int items_sent   = 0;
    int cfg_sets     = 0;

    // ---------------------------------------------------------------
    // Receiver: sample the pre-edge handshake, then pick next tready.
    // A requested hold-off is counted down here, one cycle per edge.
    // ---------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Hard stop in case the DUT hangs.
    initial begin
        #2_000_000;
        $display("%0t: timeout, %0d output bytes still owed", $time, sb.tx_expected.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic set_idle(t_idle_mode m);
        case (m)
            IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_TX:   begin tx_idle_pct = 70; rx_stall_pct = 0;  end
            IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 70; end
            IDLE_BOTH: begin tx_idle_pct = 31; rx_stall_pct = 31; end
            default: ;
        endcase
    endtask

    // One message byte; the predictor sees it at the accepting edge.
    task automatic send_item(input logic [7:0] b, input logic eom);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(b, eom);
        items_sent++;
    endtask

    // Drop tvalid and let the output side drain; every input causes at
    // least one output byte, so an empty queue means the DUT is idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.tx_expected.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_put(t_cfg_index idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // back-to-back writes keep we high; it drops once after the last one
    task automatic cfg_write_all(logic [3:0] bid, logic [7:0] dle, logic [7:0] stx,
                                 logic [7:0] etx);
        cfg_put(CFG_BOARD_NUM, {4'h0, bid});
        cfg_put(CFG_DLE_CODE, dle);
        cfg_put(CFG_STX_CODE, stx);
        cfg_put(CFG_ETX_CODE, etx);
        cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    // Random messages: mostly short, some long; bytes lean toward the
    // escape code and the extremes. A phase may stop mid-message.
    task automatic send_random_items(int n);
        logic [7:0] b;
        int         r;
        repeat (n) begin
            if (msg_left == 0) begin
                msg_left = ($urandom_range(3) == 0) ? $urandom_range(12, 1) :
                                                      $urandom_range(4, 1);
            end
            r = $urandom_range(9);
            if (r < 3)       b = sb.dle_code;
            else if (r == 3) b = 8'h00;
            else if (r == 4) b = 8'hFF;
            else             b = 8'($urandom);
            msg_left--;
            send_item(b, msg_left == 0);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        logic [15:0] crc;
        logic [3:0]  bid;
        logic [7:0]  dle;
        t_idle_mode  modes[4];

        modes = '{IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset codes: data extremes and a stuffed escape in the payload.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h10, 1'b0);
        send_item(8'h7F, 1'b1);
        // single-byte message that is itself the escape
        send_item(8'h10, 1'b1);

        // Board 5 gives mask 0x10, which collides with the escape.
        settle();
        cfg_write_all(4'd5, 8'h10, 8'h02, 8'h03);
        send_item(8'h10, 1'b1);
        send_item(8'h55, 1'b0);
        send_item(8'hAA, 1'b1);

        // Board 0: mask 0, escape 0 so mask is stuffed; STX/ETX equal to DLE.
        settle();
        cfg_write_all(4'd0, 8'h00, 8'h00, 8'h00);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        // Top board number and all-ones codes; frame left open on purpose.
        settle();
        cfg_write_all(4'd15, 8'hFF, 8'hFF, 8'hFF);
        send_item(8'hFF, 1'b1);
        send_item(8'h01, 1'b0);

        // Change codes while the frame is open; the close uses the new ones.
        settle();
        cfg_write_all(4'd8, 8'h01, 8'h02, 8'h03);
        send_item(8'h01, 1'b1);

        // Pick the escape so that each CRC byte in turn has to be stuffed.
        crc = sb.crc_step(16'h0000, 8'h01);
        crc = sb.crc_step(crc, 8'h12);
        crc = sb.crc_step(crc, 8'h34);
        settle();
        cfg_write_all(4'd1, crc[15:8], 8'h02, 8'h03);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b1);
        settle();
        cfg_write_all(4'd1, crc[7:0], 8'h02, 8'h03);
        send_item(8'h12, 1'b0);
        send_item(8'h34, 1'b1);

        // Long receiver hold-off while the sender keeps offering, so the
        // internal queue fills and s_axis_tready has to drop.
        settle();
        cfg_write_all(4'd3, 8'h10, 8'h02, 8'h03);
        set_idle(IDLE_NONE);
        rx_hold = 300;
        send_random_items(40);

        // Random phases, two register settings per idle pattern.
        foreach (modes[k]) begin
            for (int p = 0; p < 2; p++) begin
                settle();
                set_idle(modes[k]);
                bid = ($urandom_range(7) != 0) ? 4'($urandom_range(8, 1)) :
                                                 4'($urandom_range(15));
                dle = ($urandom_range(3) == 0) ? 8'h10 : 8'($urandom);
                cfg_write_all(bid, dle,
                              ($urandom_range(5) == 0) ? dle : 8'($urandom),
                              ($urandom_range(5) == 0) ? dle : 8'($urandom));
                send_random_items(55);
            end
        end

        // close any open frame, then drain
        if (msg_left != 0) begin
            send_item(8'h5A, 1'b1);
            msg_left = 0;
        end
        settle();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d input transfers and %0d output transfers, %0d frames closed,",
                 items_sent, sb.checked, sb.frames);
        $display("over %0d register settings, a long output hold-off and four idle patterns.",
                 cfg_sets);
        if (sb.errors == 0 && sb.tx_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
